// File: rtl/core/luatok_pkg.sv
package luatok_pkg;

    localparam int MaxLevelDefault = 8;

    // Token kinds as they appear on the result channel
    typedef enum logic [2:0] {
        KIND_WORD = 3'd0,
        KIND_NUM  = 3'd1,
        KIND_STR  = 3'd2,
        KIND_CHAR = 3'd3,
        KIND_ERR  = 3'd4
    } t_kind;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_QSTR,
        MODE_OPEN,
        MODE_LEVEL,
        MODE_BODY,
        MODE_CLOSE
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic        last;
        logic        empty;
        logic        kw;
    } t_item;

    // Fixed part of the work handed from the scanner to the emitter; the run of
    // pending close characters travels beside it, its width follows the level.
    typedef struct packed {
        logic  has_first;
        t_item first;
        logic  has_second;
        t_item second;
    } t_job;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam logic [2:0] KW_LEN_DO    = 3'd2;
    localparam logic [2:0] KW_LEN_END   = 3'd3;
    localparam logic [2:0] KW_LEN_WHILE = 3'd5;

    function automatic t_item mk_item(t_kind kind, logic [7:0] ch, logic last,
                                      logic empty, logic kw);
        t_item it;
        it.kind  = kind;
        it.ch    = ch;
        it.last  = last;
        it.empty = empty;
        it.kw    = kw;
        return it;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Character of keyword idx (0 do, 1 end, 2 while) at pos; zero past its end
    function automatic logic [7:0] kw_char(logic [1:0] idx, logic [2:0] pos);
        logic [7:0] r;
        unique case ({idx, pos})
            {2'd0, 3'd0}: r = 8'h64; // d
            {2'd0, 3'd1}: r = 8'h6F; // o
            {2'd1, 3'd0}: r = 8'h65; // e
            {2'd1, 3'd1}: r = 8'h6E; // n
            {2'd1, 3'd2}: r = 8'h64; // d
            {2'd2, 3'd0}: r = 8'h77; // w
            {2'd2, 3'd1}: r = 8'h68; // h
            {2'd2, 3'd2}: r = 8'h69; // i
            {2'd2, 3'd3}: r = 8'h6C; // l
            {2'd2, 3'd4}: r = 8'h65; // e
            default:      r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] kw_next_cand(logic [2:0] cand, logic [2:0] pos,
                                                logic [7:0] c);
        logic [2:0] r;
        for (int i = 0; i < 3; i++) begin
            r[i] = cand[i] && (kw_char(2'(i), pos) == c);
        end
        return r;
    endfunction

    function automatic logic kw_match(logic [2:0] cand, logic [2:0] len);
        return (cand[0] && len == KW_LEN_DO) || (cand[1] && len == KW_LEN_END) ||
               (cand[2] && len == KW_LEN_WHILE);
    endfunction

endpackage

// File: rtl/core/luatok_emit.sv
module luatok_emit #(
    parameter int MAX_LEVEL = luatok_pkg::MaxLevelDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  luatok_pkg::t_job                    i_job,
    input  logic [$clog2(MAX_LEVEL + 2) - 1:0]  i_run_cnt,
    output logic                                o_job_ready,
    output logic                                o_valid,
    input  logic                                i_ready,
    output luatok_pkg::t_item                   o_item
);
    import luatok_pkg::*;

    localparam int RunW = $clog2(MAX_LEVEL + 2);

    logic            r_has1, n_has1;
    t_item           r_item1;
    logic [RunW-1:0] r_run_cnt, n_run_cnt;
    logic            r_run_first, n_run_first;
    logic            r_has2, n_has2;
    t_item           r_item2;
    logic            r_out_valid;
    t_item           r_out;

    logic  out_free;
    logic  pending;
    logic  single;
    logic  step;
    t_item emit_item;

    assign out_free = !r_out_valid || i_ready;
    assign pending  = r_has1 || (r_run_cnt != '0) || r_has2;
    assign single   = (r_has1 && r_run_cnt == '0 && !r_has2) ||
                      (!r_has1 && r_run_cnt == RunW'(1) && !r_has2) ||
                      (!r_has1 && r_run_cnt == '0 && r_has2);
    assign step     = pending && out_free;

    assign o_job_ready = !pending || (single && out_free);
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    // Drain order: first item, the run of close characters, second item
    always_comb begin
        n_has1      = r_has1;
        n_run_cnt   = r_run_cnt;
        n_run_first = r_run_first;
        n_has2      = r_has2;
        emit_item   = r_item2;
        priority if (r_has1) begin
            emit_item = r_item1;
            n_has1    = !step;
        end else if (r_run_cnt != '0) begin
            emit_item = mk_item(KIND_STR, r_run_first ? CH_RBRACK : CH_EQ,
                                1'b0, 1'b0, 1'b0);
            if (step) begin
                n_run_cnt   = r_run_cnt - RunW'(1);
                n_run_first = 1'b0;
            end
        end else begin
            n_has2 = r_has2 && !step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has1      <= 1'b0;
            r_run_cnt   <= '0;
            r_run_first <= 1'b0;
            r_has2      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_has1      <= i_job.has_first;
                r_run_cnt   <= i_run_cnt;
                r_run_first <= 1'b1;
                r_has2      <= i_job.has_second;
            end else begin
                r_has1      <= n_has1;
                r_run_cnt   <= n_run_cnt;
                r_run_first <= n_run_first;
                r_has2      <= n_has2;
            end
            if (out_free) begin
                r_out_valid <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item1 <= i_job.first;
            r_item2 <= i_job.second;
        end
        if (out_free && step) begin
            r_out <= emit_item;
        end
    end

endmodule

// File: rtl/core/lua_subset_token_scanner.sv
// Lua subset token scanner: one source byte per input transaction, byte 0 ends the
// stream and returns the scanner to its reset state. Each result transaction carries
// one character of a token (word, number, quoted or long-bracket string, or single
// character) with kind, last, empty and keyword flags; errors give a kind 4 item.
// Rate: a byte is taken every cycle while the output side is ready, if each byte
// causes at most one result. A byte that causes more (up to MAX_LEVEL + 2, when a
// long-bracket close fails after its '=' signs) holds the input until only its last
// result is left, as the single emitter register hands out one result per cycle while the
// output is ready. Results go through the job registers, then the output register.
module lua_subset_token_scanner #(
    parameter int MAX_LEVEL = luatok_pkg::MaxLevelDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_token_kind,
    output logic [7:0] o_value_char,
    output logic       o_token_last,
    output logic       o_token_empty,
    output logic       o_is_keyword
);
    import luatok_pkg::*;

    localparam int LevW = $clog2(MAX_LEVEL + 1);
    localparam int RunW = $clog2(MAX_LEVEL + 2);

    // Scanner state
    t_mode           r_mode, n_mode;
    logic [7:0]      r_quote, n_quote;
    logic [LevW-1:0] r_level, n_level;
    logic [LevW-1:0] r_cmc, n_cmc;       // '=' signs seen after a possible close
    logic [7:0]      r_held_char, n_held_char;
    logic            r_held_valid, n_held_valid;
    t_kind           r_held_kind, n_held_kind;
    logic [2:0]      r_wl, n_wl;         // word length, saturates at 7
    logic [2:0]      r_cand, n_cand;     // keyword candidates: while, end, do

    logic            accept;
    logic            job_ready;
    t_job            job;
    logic [RunW-1:0] run_cnt;
    logic            scan_idle;
    t_item           flush_item;
    t_item           fin_item;
    t_item           err_item;
    t_item           out_item;
    logic [7:0]      c;

    assign c       = i_char_in;
    assign o_ready = job_ready;
    assign accept  = i_valid && job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_quote      <= CH_NUL;
            r_level      <= '0;
            r_cmc        <= '0;
            r_held_char  <= CH_NUL;
            r_held_valid <= 1'b0;
            r_held_kind  <= KIND_WORD;
            r_wl         <= '0;
            r_cand       <= 3'b111;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_quote      <= n_quote;
            r_level      <= n_level;
            r_cmc        <= n_cmc;
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
            r_held_kind  <= n_held_kind;
            r_wl         <= n_wl;
            r_cand       <= n_cand;
        end
    end

    always_comb begin
        // Held character goes out as a middle character of its token
        flush_item = mk_item(r_held_kind, r_held_char, 1'b0, 1'b0, 1'b0);
        // Closing item: held character marked last, or an empty string marker
        fin_item   = r_held_valid
                   ? mk_item(r_held_kind, r_held_char, 1'b1, 1'b0,
                             (r_held_kind == KIND_WORD) && kw_match(r_cand, r_wl))
                   : mk_item(KIND_STR, CH_NUL, 1'b1, 1'b1, 1'b0);
        err_item   = mk_item(KIND_ERR, CH_NUL, 1'b1, 1'b1, 1'b0);

        n_mode       = r_mode;
        n_quote      = r_quote;
        n_level      = r_level;
        n_cmc        = r_cmc;
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        n_held_kind  = r_held_kind;
        n_wl         = r_wl;
        n_cand       = r_cand;
        job          = '0;
        job.first    = flush_item;
        job.second   = err_item;
        run_cnt      = '0;
        scan_idle    = 1'b0;

        unique case (r_mode)
            MODE_IDLE: begin
                scan_idle = 1'b1;
            end
            MODE_WORD, MODE_NUM: begin
                if ((r_mode == MODE_WORD && (is_alpha(c) || is_digit(c) || c == CH_UNDER))
                    || (r_mode == MODE_NUM && is_digit(c))) begin
                    // Extend the token: release the previous character
                    job.has_first = r_held_valid;
                    n_held_char   = c;
                    n_held_valid  = 1'b1;
                    if (r_mode == MODE_WORD) begin
                        n_cand = kw_next_cand(r_cand, r_wl, c);
                        n_wl   = (r_wl == 3'd7) ? r_wl : r_wl + 3'd1;
                    end
                end else begin
                    job.has_first = 1'b1;
                    job.first     = fin_item;
                    scan_idle     = 1'b1;
                end
            end
            MODE_OPEN: begin
                if (c == CH_EQ) begin
                    n_level = LevW'(1);
                    n_mode  = MODE_LEVEL;
                end else if (c == CH_LBRACK) begin
                    n_level = '0;
                    n_mode  = MODE_BODY;
                end else begin
                    // Lone bracket: a single character token, rescan this byte
                    job.has_first = 1'b1;
                    job.first     = mk_item(KIND_CHAR, CH_LBRACK, 1'b1, 1'b0, 1'b0);
                    scan_idle     = 1'b1;
                end
            end
            MODE_QSTR: begin
                if (c == CH_NUL) begin
                    job.has_first  = r_held_valid;
                    job.has_second = 1'b1;
                end else if (c == r_quote) begin
                    job.has_first = 1'b1;
                    job.first     = fin_item;
                end else begin
                    job.has_first = r_held_valid;
                    n_held_char   = c;
                    n_held_kind   = KIND_STR;
                    n_held_valid  = 1'b1;
                end
            end
            MODE_LEVEL: begin
                if (c == CH_EQ && r_level < LevW'(MAX_LEVEL)) begin
                    n_level = r_level + LevW'(1);
                end else if (c == CH_LBRACK) begin
                    n_mode = MODE_BODY;
                end else begin
                    // Bad opener or level overflow: drop the byte
                    job.has_first  = r_held_valid;
                    job.has_second = 1'b1;
                end
            end
            MODE_BODY: begin
                if (c == CH_NUL) begin
                    job.has_first  = r_held_valid;
                    job.has_second = 1'b1;
                end else if (c == CH_RBRACK) begin
                    n_mode = MODE_CLOSE;
                    n_cmc  = '0;
                end else begin
                    job.has_first = r_held_valid;
                    n_held_char   = c;
                    n_held_kind   = KIND_STR;
                    n_held_valid  = 1'b1;
                end
            end
            MODE_CLOSE: begin
                if (c == CH_NUL) begin
                    job.has_first  = r_held_valid;
                    job.has_second = 1'b1;
                end else if (c == CH_RBRACK && r_cmc == r_level) begin
                    job.has_first = 1'b1;
                    job.first     = fin_item;
                end else if (c == CH_RBRACK) begin
                    // Failed close, new possible close: the last pending char stays held
                    job.has_first = r_held_valid;
                    run_cnt       = RunW'(r_cmc);
                    n_held_char   = (r_cmc == '0) ? CH_RBRACK : CH_EQ;
                    n_held_kind   = KIND_STR;
                    n_held_valid  = 1'b1;
                    n_cmc         = '0;
                end else if (c == CH_EQ && r_cmc < r_level) begin
                    n_cmc = r_cmc + LevW'(1);
                end else begin
                    // Failed close: pending ']' and '=' signs become content
                    job.has_first = r_held_valid;
                    run_cnt       = RunW'(r_cmc) + RunW'(1);
                    n_held_char   = c;
                    n_held_kind   = KIND_STR;
                    n_held_valid  = 1'b1;
                    n_cmc         = '0;
                    n_mode        = MODE_BODY;
                end
            end
        endcase

        // Token finished or error raised: clear the hold and go idle
        if (scan_idle || job.has_second || job.first.last) begin
            n_held_valid = 1'b0;
            n_held_char  = CH_NUL;
            n_held_kind  = KIND_WORD;
            n_mode       = MODE_IDLE;
            n_level      = '0;
            n_cmc        = '0;
        end

        // Start of a new token from idle
        if (scan_idle && c != CH_NUL && !is_space(c)) begin
            if (is_alpha(c) || c == CH_UNDER) begin
                n_mode       = MODE_WORD;
                n_wl         = 3'd1;
                n_cand       = kw_next_cand(3'b111, 3'd0, c);
                n_held_char  = c;
                n_held_kind  = KIND_WORD;
                n_held_valid = 1'b1;
            end else if (is_digit(c)) begin
                n_mode       = MODE_NUM;
                n_held_char  = c;
                n_held_kind  = KIND_NUM;
                n_held_valid = 1'b1;
            end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                n_mode  = MODE_QSTR;
                n_quote = c;
            end else if (c == CH_LBRACK) begin
                n_mode = MODE_OPEN;
            end else begin
                job.has_second = 1'b1;
                job.second     = mk_item(KIND_CHAR, c, 1'b1, 1'b0, 1'b0);
            end
        end

        // End of stream: back to the reset state
        if (c == CH_NUL) begin
            n_mode       = MODE_IDLE;
            n_quote      = CH_NUL;
            n_level      = '0;
            n_cmc        = '0;
            n_held_char  = CH_NUL;
            n_held_valid = 1'b0;
            n_held_kind  = KIND_WORD;
            n_wl         = '0;
            n_cand       = 3'b111;
        end
    end

    luatok_emit #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_job       (job),
        .i_run_cnt   (run_cnt),
        .o_job_ready (job_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (out_item)
    );

    assign o_token_kind  = out_item.kind;
    assign o_value_char  = out_item.ch;
    assign o_token_last  = out_item.last;
    assign o_token_empty = out_item.empty;
    assign o_is_keyword  = out_item.kw;

endmodule
